>>> rtl/core/nrm_pkg.sv
// Shared types and codes for the automaton line matcher.
`default_nettype none
package nrm_pkg;

	localparam int ENTRY_W = 22;

	// item opcodes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_EOL  = 2'd2;

	// node kinds
	localparam logic [1:0] KIND_EPS = 2'd0;
	localparam logic [1:0] KIND_ANY = 2'd1;
	localparam logic [1:0] KIND_LIT = 2'd2;

	// line status codes
	localparam logic [1:0] ST_NOT_FOUND = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NO_LOAD   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic [5:0] next_a;
		logic [5:0] next_b;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_STEP  = 3'b010,
		S_CLOSE = 3'b100
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/nrm_ifs.sv
// Valid/ready channel interfaces for input items and line results.
`default_nettype none
interface nrm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [5:0] entry_index;
	logic [1:0] entry_kind;
	logic [7:0] entry_symbol;
	logic [5:0] entry_next_a;
	logic [5:0] entry_next_b;
	logic [7:0] text_char;

	modport source (output valid, opcode, entry_index, entry_kind, entry_symbol,
		entry_next_a, entry_next_b, text_char, input ready);
	modport sink (input valid, opcode, entry_index, entry_kind, entry_symbol,
		entry_next_a, entry_next_b, text_char, output ready);
endinterface

interface nrm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] line_status;

	modport source (output valid, line_status, input ready);
	modport sink (input valid, line_status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/nfa_regex_line_matcher.sv
// Top level: automaton line matcher with node table and scan sequencer.
// After accept, loads and end of line run k closure passes; characters within LINE_LIMIT
// run one step pass plus k closure passes. A pass reads entries 1 to NODE_COUNT-1 through
// the single read port of the node table; k is at most the epsilon chain depth plus one.
// End-of-line status is valid the cycle after accept. Words are taken one at a time.
// Reset clears control, the active set, position, flags and the loaded mark.
`default_nettype none
module nfa_regex_line_matcher #(
	parameter int NODE_COUNT = 64,
	parameter int LINE_LIMIT = 4096
) (
	input  wire          clk,
	input  wire          arst_n,
	nrm_in_if.sink       req,
	nrm_out_if.source    rsp,
	input  wire          cfg_we,
	input  wire          cfg_wdata
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int XW = (IW + 1 > 7) ? IW + 1 : 7;
	localparam int PW = $clog2(LINE_LIMIT + 1);

	nrm_pkg::state_t  state_q;
	nrm_pkg::entry_t  rdata;
	nrm_pkg::entry_t  wentry;
	logic [IW-1:0]    cnt_q;
	logic             issue_q;
	logic             rd_v_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic [NODE_COUNT-1:0] act_q;
	logic [NODE_COUNT-1:0] nxt_q;
	logic [NODE_COUNT-1:0] add_v;
	logic [NODE_COUNT-1:0] close_v;
	logic [NODE_COUNT-1:0] seed_v;
	logic [NODE_COUNT-1:0] load_seed_v;
	logic [PW-1:0]    pos_q;
	logic             matched_q;
	logic             loaded_q;
	logic             anywhere_q;
	logic             chg_q;
	logic [7:0]       chr_q;
	logic [5:0]       seed_a_q;
	logic [5:0]       seed_b_q;
	logic             rsp_v_q;
	logic [1:0]       status_q;
	logic             acc;
	logic             hit;
	logic             last_rd;
	logic             changed_now;
	logic [XW-1:0]    idx_x;
	logic [XW-1:0]    a_x;
	logic [XW-1:0]    b_x;
	logic             wr_ok;
	logic [5:0]       ld_a;
	logic [5:0]       ld_b;

	// start set from the two successors of entry 0, out-of-range dropped
	function automatic logic [NODE_COUNT-1:0] seed_vec(input logic [5:0] a,
		input logic [5:0] b);
		logic [NODE_COUNT-1:0] v;
		logic [XW-1:0]         ax;
		logic [XW-1:0]         bx;
		v  = '0;
		ax = XW'(a);
		bx = XW'(b);
		if (ax < XW'(NODE_COUNT)) v[ax[IW-1:0]] = 1'b1;
		if (bx < XW'(NODE_COUNT)) v[bx[IW-1:0]] = 1'b1;
		return v;
	endfunction

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == nrm_pkg::S_IDLE) && (!rsp_v_q || rsp.ready);
	assign rsp.valid = rsp_v_q;
	assign rsp.line_status = status_q;

	// load decode
	assign idx_x  = XW'(req.entry_index);
	assign wr_ok  = acc && (req.opcode == nrm_pkg::OP_LOAD) && (idx_x < XW'(NODE_COUNT));
	assign wentry = '{kind: req.entry_kind, symbol: req.entry_symbol,
		next_a: req.entry_next_a, next_b: req.entry_next_b};
	assign ld_a   = (wr_ok && idx_x == '0) ? req.entry_next_a : seed_a_q;
	assign ld_b   = (wr_ok && idx_x == '0) ? req.entry_next_b : seed_b_q;
	assign seed_v      = seed_vec(seed_a_q, seed_b_q);
	assign load_seed_v = seed_vec(ld_a, ld_b);

	nrm_table #(.DEPTH(NODE_COUNT)) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (idx_x[IW-1:0]),
		.wdata (wentry),
		.raddr (cnt_q),
		.rdata (rdata)
	);

	// successor bits contributed by the entry read back this cycle
	always_comb begin
		a_x   = XW'(rdata.next_a);
		b_x   = XW'(rdata.next_b);
		add_v = '0;
		case (state_q)
			nrm_pkg::S_STEP: hit = act_q[rd_idx_s1] && (rdata.kind == nrm_pkg::KIND_ANY ||
				(rdata.kind == nrm_pkg::KIND_LIT && rdata.symbol == chr_q));
			nrm_pkg::S_CLOSE: hit = act_q[rd_idx_s1] && rdata.kind == nrm_pkg::KIND_EPS;
			default: hit = 1'b0;
		endcase
		if (rd_v_s1 && hit) begin
			if (a_x < XW'(NODE_COUNT)) add_v[a_x[IW-1:0]] = 1'b1;
			if (b_x < XW'(NODE_COUNT)) add_v[b_x[IW-1:0]] = 1'b1;
		end
	end

	assign close_v     = act_q | add_v;
	assign changed_now = |(add_v & ~act_q);
	assign last_rd     = rd_v_s1 && (rd_idx_s1 == IW'(NODE_COUNT - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nrm_pkg::S_IDLE;
			cnt_q      <= '0;
			issue_q    <= 1'b0;
			rd_v_s1    <= 1'b0;
			rd_idx_s1  <= '0;
			act_q      <= '0;
			nxt_q      <= '0;
			pos_q      <= '0;
			matched_q  <= 1'b0;
			loaded_q   <= 1'b0;
			anywhere_q <= 1'b0;
			chg_q      <= 1'b0;
			chr_q      <= '0;
			seed_a_q   <= '0;
			seed_b_q   <= '0;
			rsp_v_q    <= 1'b0;
			status_q   <= nrm_pkg::ST_NOT_FOUND;
		end else begin
			if (cfg_we) anywhere_q <= cfg_wdata;

			// result word: raised by end of line, dropped once taken
			if (acc && req.opcode == nrm_pkg::OP_EOL) rsp_v_q <= 1'b1;
			else if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;

			// read pipeline over entries 1..NODE_COUNT-1
			rd_v_s1   <= issue_q;
			rd_idx_s1 <= cnt_q;
			if (issue_q) begin
				if (cnt_q == IW'(NODE_COUNT - 1)) issue_q <= 1'b0;
				else cnt_q <= cnt_q + 1'b1;
			end

			case (state_q)
				nrm_pkg::S_IDLE: begin
					if (acc) begin
						case (req.opcode)
							nrm_pkg::OP_LOAD: begin
								if (wr_ok) begin
									loaded_q <= 1'b1;
									if (idx_x == '0) begin
										seed_a_q <= req.entry_next_a;
										seed_b_q <= req.entry_next_b;
									end
								end
								act_q     <= load_seed_v;
								pos_q     <= '0;
								matched_q <= 1'b0;
								cnt_q     <= IW'(1);
								issue_q   <= 1'b1;
								chg_q     <= 1'b0;
								state_q   <= nrm_pkg::S_CLOSE;
							end
							nrm_pkg::OP_CHAR: begin
								if (pos_q < PW'(LINE_LIMIT)) begin
									pos_q   <= pos_q + 1'b1;
									chr_q   <= req.text_char;
									nxt_q   <= '0;
									cnt_q   <= IW'(1);
									issue_q <= 1'b1;
									state_q <= nrm_pkg::S_STEP;
								end
							end
							nrm_pkg::OP_EOL: begin
								if (!loaded_q || (seed_a_q == '0 && seed_b_q == '0))
									status_q <= nrm_pkg::ST_NO_LOAD;
								else if (matched_q)
									status_q <= nrm_pkg::ST_FOUND;
								else
									status_q <= nrm_pkg::ST_NOT_FOUND;
								act_q     <= seed_v;
								pos_q     <= '0;
								matched_q <= 1'b0;
								cnt_q     <= IW'(1);
								issue_q   <= 1'b1;
								chg_q     <= 1'b0;
								state_q   <= nrm_pkg::S_CLOSE;
							end
							default: ;
						endcase
					end
				end
				nrm_pkg::S_STEP: begin
					nxt_q <= nxt_q | add_v;
					if (last_rd) begin
						act_q   <= nxt_q | add_v | (anywhere_q ? seed_v : '0);
						cnt_q   <= IW'(1);
						issue_q <= 1'b1;
						chg_q   <= 1'b0;
						state_q <= nrm_pkg::S_CLOSE;
					end
				end
				nrm_pkg::S_CLOSE: begin
					act_q <= close_v;
					chg_q <= chg_q | changed_now;
					if (last_rd) begin
						if (chg_q || changed_now) begin
							// another pass until nothing new is reached
							cnt_q   <= IW'(1);
							issue_q <= 1'b1;
							chg_q   <= 1'b0;
						end else begin
							matched_q <= matched_q | close_v[0];
							state_q   <= nrm_pkg::S_IDLE;
						end
					end
				end
				default: state_q <= nrm_pkg::S_IDLE;
			endcase
		end
	end

	// a new result only follows an accepted end-of-line word
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_v_q) |-> $past(acc && req.opcode == nrm_pkg::OP_EOL))
		else $error("result without end of line");

	// a load always restarts the line with a closure
	a_load_close: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.opcode == nrm_pkg::OP_LOAD) |=> state_q == nrm_pkg::S_CLOSE)
		else $error("load did not start closure");

	// table reads only come back while a scan is running
	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q != nrm_pkg::S_IDLE)
		else $error("read data while idle");

	// the entry 0 is never read by a scan
	a_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> rd_idx_s1 != '0)
		else $error("start entry scanned");

endmodule
`default_nettype wire

>>> rtl/core/nrm_table.sv
// Node table: single-port-write, registered-read memory.
`default_nettype none
module nrm_table #(
	parameter int DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              we,
	input  wire  [$clog2(DEPTH)-1:0]         waddr,
	input  var   nrm_pkg::entry_t            wdata,
	input  wire  [$clog2(DEPTH)-1:0]         raddr,
	output nrm_pkg::entry_t                  rdata
);

	nrm_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
